[src/dpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dpa_pkg;

    // default sizes handed to the top level parameters
    localparam int NUM_PATHS_DEF = 8;
    localparam int TAG_BITS_DEF  = 8;

    // fixed field widths
    localparam int CH_W      = 4;
    localparam int SF_W      = 4;
    localparam int PWR_W     = 12;
    localparam int ST_W      = 3;
    localparam int PIDX_W    = 3;
    localparam int CNT_W     = 4;
    localparam int MAP_W     = 32;
    localparam int CFG_IDX_W = 2;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // status codes
    localparam logic [ST_W-1:0] ST_LOCKED = 3'd0;
    localparam logic [ST_W-1:0] ST_BELOW  = 3'd1;
    localparam logic [ST_W-1:0] ST_NOPATH = 3'd2;
    localparam logic [ST_W-1:0] ST_FREED  = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTAG  = 3'd4;
    localparam logic [ST_W-1:0] ST_BADSF  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATHS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTH     = 2'd2;

    localparam logic [CNT_W-1:0] PATHS_RESET = 4'd8;
    localparam logic [CNT_W-1:0] CNT_MAX     = 4'd15;

    localparam logic [SF_W-1:0] SF_MIN = 4'd7;
    localparam logic [SF_W-1:0] SF_MAX = 4'd12;

    typedef struct packed {
        logic              lock;
        logic              free;
        logic [PIDX_W-1:0] idx;
    } t_path_cmd;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [PIDX_W-1:0] path_index;
        logic [CNT_W-1:0]  occupied;
        logic              end_scheduled;
    } t_result;

    function automatic logic sf_ok(input logic [SF_W-1:0] sf);
        return (sf >= SF_MIN) && (sf <= SF_MAX);
    endfunction

    // sensitivity in tenths of dBm per spreading factor
    function automatic logic signed [PWR_W-1:0] sens_thresh(input logic [SF_W-1:0] sf);
        logic signed [PWR_W-1:0] t;
        case (sf)
            4'd7:    t = -12'sd1300;
            4'd8:    t = -12'sd1325;
            4'd9:    t = -12'sd1350;
            4'd10:   t = -12'sd1375;
            4'd11:   t = -12'sd1400;
            4'd12:   t = -12'sd1425;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[src/dpa_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dpa_in_if #(
    parameter int TAG_BITS = dpa_pkg::TAG_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [dpa_pkg::CH_W-1:0]           channel;
    logic [dpa_pkg::SF_W-1:0]           spreading_factor;
    logic signed [dpa_pkg::PWR_W-1:0]   rx_power;
    logic [TAG_BITS-1:0]                event_tag;
    logic                               jammer;

    modport source (
        output valid, kind, channel, spreading_factor, rx_power, event_tag, jammer,
        input  ready
    );
    modport sink (
        input  valid, kind, channel, spreading_factor, rx_power, event_tag, jammer,
        output ready
    );
endinterface

`default_nettype wire

[src/dpa_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dpa_out_if;
    logic                          valid;
    logic                          ready;
    logic [dpa_pkg::ST_W-1:0]      status;
    logic [dpa_pkg::PIDX_W-1:0]    path_index;
    logic [dpa_pkg::CNT_W-1:0]     occupied;
    logic                          end_scheduled;

    modport source (
        output valid, status, path_index, occupied, end_scheduled,
        input  ready
    );
    modport sink (
        input  valid, status, path_index, occupied, end_scheduled,
        output ready
    );
endinterface

`default_nettype wire

[src/dpa_paths.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpa_paths #(
    parameter int NUM_PATHS = dpa_pkg::NUM_PATHS_DEF,
    parameter int TAG_BITS  = dpa_pkg::TAG_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dpa_pkg::t_path_cmd         i_cmd,
    input  wire logic [TAG_BITS-1:0]        i_tag,
    input  wire logic [(NUM_PATHS > 1 ? $clog2(NUM_PATHS) : 1)-1:0] i_rd_idx,
    output logic                            o_busy,
    output logic [TAG_BITS-1:0]             o_tag,
    output logic [dpa_pkg::CNT_W-1:0]       o_count
);
    import dpa_pkg::*;

    localparam int AW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;

    logic [NUM_PATHS-1:0] r_busy;
    logic [NUM_PATHS-1:0] n_busy;
    logic [TAG_BITS-1:0]  r_event [NUM_PATHS];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [AW-1:0]        w_idx;

    assign w_idx = i_cmd.idx[AW-1:0];

    always_comb begin
        n_busy  = r_busy;
        n_count = r_count;
        if (i_cmd.lock) begin
            n_busy[w_idx] = 1'b1;
            if (r_count < CNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end else if (i_cmd.free) begin
            n_busy[w_idx] = 1'b0;
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= '0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_count <= n_count;
        end
    end

    // tag store, only read behind a busy bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.lock) begin
            r_event[w_idx] <= i_tag;
        end
    end

    assign o_busy  = r_busy[i_rd_idx];
    assign o_tag   = r_event[i_rd_idx];
    assign o_count = r_count;

endmodule

`default_nettype wire

[src/dpa_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpa_seq #(
    parameter int NUM_PATHS = dpa_pkg::NUM_PATHS_DEF,
    parameter int TAG_BITS  = dpa_pkg::TAG_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_kind,
    input  wire logic [dpa_pkg::CH_W-1:0]      i_channel,
    input  wire logic [dpa_pkg::SF_W-1:0]      i_sf,
    input  wire logic signed [dpa_pkg::PWR_W-1:0] i_power,
    input  wire logic [TAG_BITS-1:0]           i_tag,
    input  wire logic                          i_jammer,
    input  wire logic [dpa_pkg::MAP_W-1:0]     i_map,
    input  wire logic [dpa_pkg::CNT_W-1:0]     i_paths,
    input  wire logic                          i_auth,
    input  wire logic                          i_busy,
    input  wire logic [TAG_BITS-1:0]           i_path_tag,
    input  wire logic [dpa_pkg::CNT_W-1:0]     i_count,
    input  wire logic                          i_out_free,
    output logic                               o_idle,
    output logic [(NUM_PATHS > 1 ? $clog2(NUM_PATHS) : 1)-1:0] o_rd_idx,
    output logic [TAG_BITS-1:0]                o_tag,
    output dpa_pkg::t_path_cmd                 o_cmd,
    output logic                               o_res_valid,
    output dpa_pkg::t_result                   o_res
);
    import dpa_pkg::*;

    localparam int AW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam int CW = $clog2(NUM_PATHS + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                r_state;
    logic                n_state;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       n_idx;

    // item held for the scan
    logic                r_kind;
    logic [CH_W-1:0]     r_chan;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_bad;
    logic                r_below;
    logic                r_sched;

    logic [CNT_W-1:0]    w_live;
    logic [AW-1:0]       w_rd;
    logic [CH_W-1:0]     w_path_ch;
    logic                w_scan_end;
    logic                w_done;
    t_result             w_res;
    t_path_cmd           w_cmd;

    assign w_live     = (i_paths > CNT_W'(NUM_PATHS)) ? CNT_W'(NUM_PATHS) : i_paths;
    assign w_rd       = r_idx[AW-1:0];
    assign w_path_ch  = i_map[w_rd*CH_W +: CH_W];
    assign w_scan_end = CNT_W'(r_idx) >= w_live;

    // one path looked at per cycle; a finished scan holds on its path until the output slot is free
    always_comb begin
        w_done = 1'b0;
        w_res  = '{status: ST_NOPATH, path_index: '0, occupied: i_count, end_scheduled: 1'b0};
        w_cmd  = '{lock: 1'b0, free: 1'b0, idx: PIDX_W'(w_rd)};
        if (r_kind == KIND_START && r_bad) begin
            w_done       = 1'b1;
            w_res.status = ST_BADSF;
        end else if (w_scan_end) begin
            w_done       = 1'b1;
            w_res.status = (r_kind == KIND_END) ? ST_NOTAG : ST_NOPATH;
        end else if (r_kind == KIND_START) begin
            if (w_path_ch == r_chan && !i_busy) begin
                w_done = 1'b1;
                if (r_below) begin
                    w_res.status = ST_BELOW;
                end else begin
                    w_res.status        = ST_LOCKED;
                    w_res.path_index    = PIDX_W'(w_rd);
                    w_res.end_scheduled = r_sched;
                    w_res.occupied      = (i_count < CNT_MAX) ? i_count + 1'b1 : i_count;
                    w_cmd.lock          = 1'b1;
                end
            end
        end else begin
            if (i_busy && i_path_tag == r_tag) begin
                w_done           = 1'b1;
                w_res.status     = ST_FREED;
                w_res.path_index = PIDX_W'(w_rd);
                w_res.occupied   = (i_count != '0) ? i_count - 1'b1 : i_count;
                w_cmd.free       = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_res_valid = 1'b0;
        o_cmd       = '{lock: 1'b0, free: 1'b0, idx: '0};
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (w_done) begin
                    // hold the result until the output slot is free
                    if (i_out_free) begin
                        o_res_valid = 1'b1;
                        o_cmd       = w_cmd;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kind  <= i_kind;
            r_chan  <= i_channel;
            r_tag   <= i_tag;
            r_bad   <= !sf_ok(i_sf);
            r_below <= i_power < sens_thresh(i_sf);
            r_sched <= !(i_auth && i_jammer);
        end
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_rd_idx = w_rd;
    assign o_tag    = r_tag;
    assign o_res    = w_res;

endmodule

`default_nettype wire

[src/demodulator_path_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// demodulator path allocator: a start item takes the lowest-numbered free path
// tuned to its channel (or is dropped below sensitivity), an end item frees the
// busy path that holds its tag; one result item per input item. a single path
// compare steps through the paths, one per cycle, so an item occupies the block
// until the scan ends on a hit, a bad spreading factor or the end of the live paths
// and its result goes into the output register; live paths is paths_in_use capped
// at NUM_PATHS. the input is not ready while a scan runs. the result sits in an
// output register; a finished scan waits there if that register is still full.
// configuration writes take effect at once and belong only to idle times.
module demodulator_path_allocator #(
    parameter int NUM_PATHS = dpa_pkg::NUM_PATHS_DEF,
    parameter int TAG_BITS  = dpa_pkg::TAG_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dpa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dpa_pkg::MAP_W-1:0]     i_cfg_data,
    dpa_in_if.sink                             i_in,
    dpa_out_if.source                          o_out
);
    import dpa_pkg::*;

    localparam int AW = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;

    // configuration registers
    logic [MAP_W-1:0]    r_map;
    logic [CNT_W-1:0]    r_paths;
    logic                r_auth;

    // output register
    logic                r_out_valid;
    logic                n_out_valid;
    t_result             r_out;

    logic                w_start;
    logic                w_idle;
    logic                w_out_free;
    logic [AW-1:0]       w_rd_idx;
    logic                w_busy;
    logic [TAG_BITS-1:0] w_path_tag;
    logic [TAG_BITS-1:0] w_tag;
    logic [CNT_W-1:0]    w_count;
    t_path_cmd           w_cmd;
    logic                w_res_valid;
    t_result             w_res;

    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_paths <= PATHS_RESET;
            r_auth  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHAN_MAP: r_map   <= i_cfg_data;
                CFG_PATHS:    r_paths <= i_cfg_data[CNT_W-1:0];
                CFG_AUTH:     r_auth  <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // sequencer with the shared path compare
    dpa_seq #(
        .NUM_PATHS (NUM_PATHS),
        .TAG_BITS  (TAG_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_kind      (i_in.kind),
        .i_channel   (i_in.channel),
        .i_sf        (i_in.spreading_factor),
        .i_power     (i_in.rx_power),
        .i_tag       (i_in.event_tag),
        .i_jammer    (i_in.jammer),
        .i_map       (r_map),
        .i_paths     (r_paths),
        .i_auth      (r_auth),
        .i_busy      (w_busy),
        .i_path_tag  (w_path_tag),
        .i_count     (w_count),
        .i_out_free  (w_out_free),
        .o_idle      (w_idle),
        .o_rd_idx    (w_rd_idx),
        .o_tag       (w_tag),
        .o_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // busy bits, locked tags and occupancy count
    dpa_paths #(
        .NUM_PATHS (NUM_PATHS),
        .TAG_BITS  (TAG_BITS)
    ) u_paths (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_tag    (w_tag),
        .i_rd_idx (w_rd_idx),
        .o_busy   (w_busy),
        .o_tag    (w_path_tag),
        .o_count  (w_count)
    );

    // the sequencer only finishes into a free slot
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.path_index    = r_out.path_index;
    assign o_out.occupied      = r_out.occupied;
    assign o_out.end_scheduled = r_out.end_scheduled;

    // occupancy never counts more paths than exist
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.occupied <= CNT_W'(NUM_PATHS)))
        else $error("occupancy above path count");

    // an accepted item blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after accept");

    // only a lock can announce a later end
    a_sched_only_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_LOCKED) |-> !r_out.end_scheduled)
        else $error("end scheduled without lock");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_res_valid)
        else $error("result overwritten");

endmodule

`default_nettype wire
